// ===== hdl/gerge_pkg.sv =====
// Shared types and constants of the grid error metrics block.
package gerge_pkg;
    localparam int unsigned MaxRows    = 1024;
    localparam int unsigned MaxCols    = 1024;
    localparam int unsigned SampleBits = 20;
    localparam int unsigned FracBits   = 12;

    localparam int unsigned CfgIdxBits  = 2;
    localparam int unsigned CfgDataBits = 16;
    localparam logic [CfgIdxBits-1:0] CfgRowCount = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgColCount = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgInvDhSq  = 2'd2;
    localparam logic [CfgIdxBits-1:0] CfgFieldEn  = 2'd3;

    localparam int unsigned RmseBits   = 21;
    localparam int unsigned EnergyBits = 63;
    localparam int unsigned SqSumBits  = 61;

    typedef enum logic [2:0] {
        t_ST_STREAM,
        t_ST_DIVIDE,
        t_ST_SQRT,
        t_ST_SCALE,
        t_ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic start_div;
        logic start_sqrt;
        logic start_scale;
        logic load_out;
        logic clear_frame;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic unit_done;
        logic draining;
    } t_status;
endpackage

// ===== hdl/gerge_if.sv =====
// Valid/ready channel interface.
interface gerge_if #(parameter int unsigned W = 1) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/gerge_ram.sv =====
// Generic single-port-write, registered-read RAM.
module gerge_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hdl/gerge_ctrl.sv =====
// Frame controller state machine.
module gerge_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gerge_pkg::t_status  i_status,
    input  logic                i_out_ready,
    output gerge_pkg::t_cmd     o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);
    gerge_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gerge_pkg::t_ST_STREAM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gerge_pkg::t_ST_STREAM: if (i_status.frame_end) n_state = gerge_pkg::t_ST_DIVIDE;
            gerge_pkg::t_ST_DIVIDE: if (i_status.unit_done) n_state = gerge_pkg::t_ST_SQRT;
            gerge_pkg::t_ST_SQRT:   if (i_status.unit_done) n_state = gerge_pkg::t_ST_SCALE;
            gerge_pkg::t_ST_SCALE:  if (i_status.unit_done) n_state = gerge_pkg::t_ST_OUTPUT;
            gerge_pkg::t_ST_OUTPUT: if (i_out_ready) n_state = gerge_pkg::t_ST_STREAM;
            default: n_state = gerge_pkg::t_ST_STREAM;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            gerge_pkg::t_ST_STREAM: begin
                // close the input once the last pair of the frame is in the pipeline
                o_in_ready        = !i_status.draining;
                o_cmd.start_div   = i_status.frame_end;
            end
            gerge_pkg::t_ST_DIVIDE: o_cmd.start_sqrt  = i_status.unit_done;
            gerge_pkg::t_ST_SQRT:   o_cmd.start_scale = i_status.unit_done;
            gerge_pkg::t_ST_SCALE: begin
                o_cmd.load_out    = i_status.unit_done;
                o_cmd.clear_frame = i_status.unit_done;
            end
            gerge_pkg::t_ST_OUTPUT: o_out_valid = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end
endmodule

// ===== hdl/gerge_dp.sv =====
// Datapath: line stores, accumulators, divider, square root and scaling.
module gerge_dp #(
    parameter int unsigned MAX_ROWS    = gerge_pkg::MaxRows,
    parameter int unsigned MAX_COLS    = gerge_pkg::MaxCols,
    parameter int unsigned SAMPLE_BITS = gerge_pkg::SampleBits
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_fire,
    input  logic signed [SAMPLE_BITS-1:0]   i_ref,
    input  logic signed [SAMPLE_BITS-1:0]   i_test,
    input  logic [10:0]                     i_row_count,
    input  logic [10:0]                     i_col_count,
    input  logic [15:0]                     i_inv_dh_sq,
    input  logic                            i_field_en,
    input  gerge_pkg::t_cmd                 i_cmd,
    output gerge_pkg::t_status              o_status,
    output logic [gerge_pkg::RmseBits-1:0]  o_rmse,
    output logic [gerge_pkg::EnergyBits-1:0] o_err_energy,
    output logic [gerge_pkg::EnergyBits-1:0] o_ref_energy
);
    localparam int unsigned DW  = SAMPLE_BITS + 1;
    localparam int unsigned CW  = $clog2(MAX_COLS);
    localparam int unsigned RPW = $clog2(MAX_ROWS + 1);
    localparam int unsigned CPW = $clog2(MAX_COLS + 1);
    localparam int unsigned SQW = 2 * DW + 2;
    localparam int unsigned EW  = gerge_pkg::EnergyBits;
    localparam int unsigned SW  = gerge_pkg::SqSumBits;
    localparam int unsigned NW  = RPW + CPW;
    localparam logic [EW-1:0] Sat63 = {EW{1'b1}};
    localparam logic [SW-1:0] Sat61 = {SW{1'b1}};

    // stage 1 registers: sample, line store read in flight
    logic                 r_s1_v, r_s1_grad, r_s1_en;
    logic signed [DW-1:0] r_s1_d, r_s1_ld;
    logic signed [SAMPLE_BITS-1:0] r_s1_r, r_s1_lr;
    logic                 r_s1_end;
    // stage 2: squares
    logic                 r_s2_v, r_s2_grad, r_s2_en, r_s2_end;
    logic [SQW-1:0]       r_sq, r_eu, r_el, r_fu, r_fl;
    logic                 r_s3_end;

    logic signed [DW-1:0]          r_left_d;
    logic signed [SAMPLE_BITS-1:0] r_left_r;
    logic [RPW-1:0] r_row;
    logic [CPW-1:0] r_col;
    logic [SW-1:0]  r_sq_sum;
    logic [EW-1:0]  r_err_sum, r_ref_sum;

    logic [RPW-1:0] w_rows;
    logic [CPW-1:0] w_cols;
    always_comb begin
        w_rows = (i_row_count < 11'd2) ? RPW'(2) :
                 ({21'd0, i_row_count} > 32'(MAX_ROWS)) ? RPW'(MAX_ROWS) : RPW'(i_row_count);
        w_cols = (i_col_count < 11'd2) ? CPW'(2) :
                 ({21'd0, i_col_count} > 32'(MAX_COLS)) ? CPW'(MAX_COLS) : CPW'(i_col_count);
    end

    logic signed [DW-1:0] w_d;
    logic [CW-1:0]        w_c;
    logic                 w_last_col, w_last_row;
    assign w_d = DW'(i_ref) - DW'(i_test);
    assign w_c = r_col[CW-1:0];
    assign w_last_col = (r_col + CPW'(1)) >= w_cols;
    assign w_last_row = (r_row + RPW'(1)) >= w_rows;

    logic [DW-1:0]          w_up_d;
    logic [SAMPLE_BITS-1:0] w_up_r;
    gerge_ram #(.WIDTH(DW), .DEPTH(MAX_COLS)) u_diff_row (
        .i_clk(i_clk), .i_we(i_in_fire), .i_waddr(w_c), .i_wdata(w_d),
        .i_raddr(w_c), .o_rdata(w_up_d));
    gerge_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_ref_row (
        .i_clk(i_clk), .i_we(i_in_fire), .i_waddr(w_c), .i_wdata(i_ref),
        .i_raddr(w_c), .o_rdata(w_up_r));

    function automatic logic [SQW-1:0] sq(input logic signed [DW:0] v);
        logic [DW:0] a;
        a = v[DW] ? -v : v;
        return SQW'(a) * SQW'(a);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_frame) begin
            r_row <= '0; r_col <= '0; r_left_d <= '0; r_left_r <= '0;
        end else if (i_in_fire) begin
            r_left_d <= w_d;
            r_left_r <= i_ref;
            if (!w_last_col) begin
                r_col <= r_col + CPW'(1);
            end else begin
                r_col <= '0;
                if (!w_last_row) r_row <= r_row + RPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s1_end <= 1'b0; r_s2_end <= 1'b0;
            r_s3_end <= 1'b0;
        end else begin
            r_s1_v   <= i_in_fire;
            r_s1_end <= i_in_fire && w_last_col && w_last_row;
            r_s2_v   <= r_s1_v;
            r_s2_end <= r_s1_end;
            r_s3_end <= r_s2_end;
        end
        r_s1_grad <= (r_row != '0) && (w_c != '0);
        r_s1_en   <= i_field_en;
        r_s1_d    <= w_d;
        r_s1_ld   <= r_left_d;
        r_s1_r    <= i_ref;
        r_s1_lr   <= r_left_r;
        r_s2_grad <= r_s1_grad;
        r_s2_en   <= r_s1_en;
        r_sq <= sq((DW+1)'(r_s1_d));
        r_eu <= sq((DW+1)'(r_s1_d) - (DW+1)'($signed(w_up_d)));
        r_el <= sq((DW+1)'(r_s1_d) - (DW+1)'(r_s1_ld));
        r_fu <= sq((DW+1)'(r_s1_r) - (DW+1)'($signed(w_up_r)));
        r_fl <= sq((DW+1)'(r_s1_r) - (DW+1)'(r_s1_lr));
    end

    logic [EW:0] w_e, w_f, w_es, w_fs;
    logic [SW:0] w_ss;
    always_comb begin
        w_e  = (EW+1)'(r_eu) + (EW+1)'(r_el);
        w_f  = (EW+1)'(r_fu) + (EW+1)'(r_fl);
        w_es = (EW+1)'(r_err_sum) + w_e;
        w_fs = (EW+1)'(r_ref_sum) + w_f;
        w_ss = (SW+1)'(r_sq_sum) + (SW+1)'(r_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_frame) begin
            r_sq_sum <= '0; r_err_sum <= '0; r_ref_sum <= '0;
        end else if (r_s2_v) begin
            r_sq_sum <= w_ss[SW] ? Sat61 : w_ss[SW-1:0];
            if (r_s2_grad) begin
                r_err_sum <= w_es[EW] ? Sat63 : w_es[EW-1:0];
                if (r_s2_en) r_ref_sum <= w_fs[EW] ? Sat63 : w_fs[EW-1:0];
            end
        end
    end

    // divisor, restoring divider one bit a cycle
    logic [NW-1:0] r_n;
    logic [SW-1:0] r_q, r_rem_src;
    logic [NW:0]   r_rem;
    logic [6:0]    r_cnt;
    logic          r_busy, r_done;
    // isqrt state
    logic [SW+1:0] r_x, r_r, r_bit;
    logic          r_sq_busy;
    // scale state
    logic [1:0]    r_sc_step;
    logic          r_sc_busy;
    logic [47:0]   r_hi_e, r_hi_f, r_lo_e, r_lo_f;

    logic [NW:0] w_rem_sh;
    assign w_rem_sh = {r_rem[NW-1:0], r_rem_src[SW-1]};

    logic [SW+1:0] w_trial;
    assign w_trial = r_r + r_bit;

    function automatic logic [EW-1:0] fin(input logic [47:0] hi, input logic [47:0] lo);
        logic [EW:0] s;
        if (hi[47:40] != '0) return Sat63;
        s = {1'b0, hi[39:0], 23'd0} + (EW+1)'(lo[40:0]);
        return s[EW] ? Sat63 : s[EW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_sq_busy <= 1'b0; r_sc_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start_div) begin
                r_busy    <= 1'b1;
                r_cnt     <= 7'(SW);
                r_rem     <= '0;
                r_rem_src <= r_sq_sum;
                r_n       <= NW'(w_rows) * NW'(w_cols);
            end else if (r_busy) begin
                r_rem_src <= r_rem_src << 1;
                if (w_rem_sh >= {1'b0, r_n}) begin
                    r_rem <= w_rem_sh - {1'b0, r_n};
                    r_q   <= {r_q[SW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_q   <= {r_q[SW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin r_busy <= 1'b0; r_done <= 1'b1; end
            end
            if (i_cmd.start_sqrt) begin
                r_sq_busy <= 1'b1;
                r_x   <= (SW+2)'(r_q);
                r_r   <= '0;
                r_bit <= (SW+2)'(1) << 62;
            end else if (r_sq_busy) begin
                if (r_bit == '0) begin
                    r_sq_busy <= 1'b0; r_done <= 1'b1;
                end else begin
                    if (r_x >= w_trial) begin
                        r_x <= r_x - w_trial;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            if (i_cmd.start_scale) begin
                r_sc_busy <= 1'b1; r_sc_step <= 2'd0;
            end else if (r_sc_busy) begin
                r_sc_step <= r_sc_step + 2'd1;
                if (r_sc_step == 2'd0) begin
                    r_hi_e <= 48'(r_err_sum[EW-1:32]) * 48'(i_inv_dh_sq);
                    r_hi_f <= 48'(r_ref_sum[EW-1:32]) * 48'(i_inv_dh_sq);
                    r_lo_e <= 48'(r_err_sum[31:0]) * 48'(i_inv_dh_sq);
                    r_lo_f <= 48'(r_ref_sum[31:0]) * 48'(i_inv_dh_sq);
                end else begin
                    r_lo_e <= r_lo_e >> 9;
                    r_lo_f <= r_lo_f >> 9;
                    r_sc_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_rmse       <= r_r[gerge_pkg::RmseBits-1:0];
            o_err_energy <= fin(r_hi_e, r_lo_e);
            o_ref_energy <= i_field_en ? fin(r_hi_f, r_lo_f) : '0;
        end
    end

    assign o_status.frame_end = r_s3_end;
    assign o_status.unit_done = r_done;
    assign o_status.draining  = r_s1_end | r_s2_end | r_s3_end;
endmodule

// ===== hdl/grid_error_rmse_gradient_energy.sv =====
// Top level of the grid error metrics block.
// Channels: in_if carries {ref_sample, test_sample} pairs of one frame in
// row-major order; out_if carries {rmse_value, error_energy, field_energy}.
// A configuration write port sets row_count, col_count, inv_dh_sq and field_energy_enable
// (indexes 0 to 3); the user must write only while the block is idle, not enforced.
// Throughput: one sample pair per cycle within a frame; two line-store RAMs
// hold the previous row, read one cycle and squared in the next.
// Ready drops right after the last pair is taken; the result becomes valid
// after the pipeline drain, a bit-serial divider over the 61-bit square
// sum, a radix-4 square root and a two-step energy scaling.
// The result is then held with valid until taken; a stalled receiver keeps
// the input channel closed until the transaction completes, so the next
// frame can start in the cycle after the result is taken at the earliest.
// Synchronous reset clears the row and column counters and the sums and
// restores configuration register defaults; the line stores need no clearing.
module grid_error_rmse_gradient_energy #(
    parameter int unsigned MAX_ROWS    = gerge_pkg::MaxRows,
    parameter int unsigned MAX_COLS    = gerge_pkg::MaxCols,
    parameter int unsigned SAMPLE_BITS = gerge_pkg::SampleBits
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gerge_pkg::CfgIdxBits-1:0]    i_cfg_index,
    input  logic [gerge_pkg::CfgDataBits-1:0]   i_cfg_data,
    gerge_if.sink                               in_if,
    gerge_if.source                             out_if
);
    logic [10:0] r_row_count, r_col_count;
    logic [15:0] r_inv_dh_sq;
    logic        r_field_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= 11'd1024; r_col_count <= 11'd1024;
            r_inv_dh_sq <= 16'd256;  r_field_en  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gerge_pkg::CfgRowCount: r_row_count <= i_cfg_data[10:0];
                gerge_pkg::CfgColCount: r_col_count <= i_cfg_data[10:0];
                gerge_pkg::CfgInvDhSq:  r_inv_dh_sq <= i_cfg_data;
                gerge_pkg::CfgFieldEn:  r_field_en  <= i_cfg_data[0];
                default: r_field_en <= r_field_en;
            endcase
        end
    end

    gerge_pkg::t_cmd    w_cmd;
    gerge_pkg::t_status w_status;
    logic w_in_ready, w_out_valid;
    logic [gerge_pkg::RmseBits-1:0]   w_rmse;
    logic [gerge_pkg::EnergyBits-1:0] w_ee, w_fe;

    assign in_if.ready  = w_in_ready;
    assign out_if.valid = w_out_valid;
    assign out_if.data  = {w_rmse, w_ee, w_fe};

    gerge_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_status(w_status),
        .i_out_ready(out_if.ready), .o_cmd(w_cmd), .o_in_ready(w_in_ready),
        .o_out_valid(w_out_valid));

    gerge_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(in_if.valid && w_in_ready),
        .i_ref(in_if.data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_test(in_if.data[SAMPLE_BITS-1:0]),
        .i_row_count(r_row_count), .i_col_count(r_col_count),
        .i_inv_dh_sq(r_inv_dh_sq), .i_field_en(r_field_en),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_rmse(w_rmse), .o_err_energy(w_ee), .o_ref_energy(w_fe));
endmodule

// ===== hdl/gerge_checker.sv =====
// Port-level checker for the grid error metrics block.
module gerge_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input open while result pending");
    a_accept_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |-> !out_valid) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready |=> !out_valid && in_ready)
        else $error("no return to streaming");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind grid_error_rmse_gradient_energy gerge_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready));

// ===== tb/sv/tb_grid_error_rmse_gradient_energy.sv =====
// Self-checking testbench of the grid error metrics block.
module tb_grid_error_rmse_gradient_energy;
    localparam int unsigned SB     = gerge_pkg::SampleBits;
    localparam int unsigned RmseW  = gerge_pkg::RmseBits;
    localparam int unsigned EnerW  = gerge_pkg::EnergyBits;
    localparam int unsigned IdxW   = gerge_pkg::CfgIdxBits;
    localparam int unsigned DataW  = gerge_pkg::CfgDataBits;

    typedef struct packed {
        logic [RmseW-1:0] rmse;
        logic [EnerW-1:0] err_energy;
        logic [EnerW-1:0] fld_energy;
    } t_metrics;

    typedef struct {
        logic [SB-1:0] ref_s;
        logic [SB-1:0] test_s;
        bit            typed;
        t_metrics      want;
    } t_stim_row;

    localparam longint unsigned Sat63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned Sat61 = 64'h1FFF_FFFF_FFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IdxW-1:0]  i_cfg_index = gerge_pkg::CfgRowCount;
    logic [DataW-1:0] i_cfg_data = '0;

    gerge_if #(.W(2*SB)) in_ch (i_clk);
    gerge_if #(.W($bits(t_metrics))) out_ch (i_clk);

    grid_error_rmse_gradient_energy u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_if       (in_ch),
        .out_if      (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Model copy of registers and frame state
    int unsigned      m_rows = 1024, m_cols = 1024, m_inv = 256;
    bit               m_fld_en = 1'b1;
    longint           diff_line [gerge_pkg::MaxCols];
    longint           ref_line [gerge_pkg::MaxCols];
    longint           left_diff, left_ref;
    int unsigned      row_pos, col_pos;
    longint unsigned  sq_sum, grad_err, grad_fld;

    t_metrics         metrics_q [$];
    int unsigned      mismatches = 0;
    int unsigned      items_sent = 0;
    int unsigned      frames_seen = 0;
    bit               burst_mode = 1'b0;
    bit               rx_burst = 1'b0;
    bit               hold_req = 1'b0;

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                                longint unsigned cap);
        if (a > cap || b > cap - a) return cap;
        return a + b;
    endfunction

    function automatic longint unsigned square_mag(longint v);
        longint unsigned a;
        a = (v < 0) ? longint'(-v) : longint'(v);
        return a * a;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned scale_energy(longint unsigned s, int unsigned k);
        longint unsigned hi, lo;
        hi = (s >> 32) * longint'(k);
        lo = ((s & 64'hFFFF_FFFF) * longint'(k)) >> 9;
        if (hi >= (64'd1 << 40)) return Sat63;
        return add_sat(hi << 23, lo, Sat63);
    endfunction

    function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
        return v < 2 ? 2 : (v > hi ? hi : v);
    endfunction

    function automatic void clear_frame_state();
        left_diff = 0;
        left_ref = 0;
        row_pos = 0;
        col_pos = 0;
        sq_sum = 0;
        grad_err = 0;
        grad_fld = 0;
    endfunction

    // Advance the frame state by one sample pair; report the frame result if it ends here
    function automatic bit step_metrics(logic [SB-1:0] rs, logic [SB-1:0] ts,
                                        output t_metrics res);
        int unsigned rows, cols;
        longint r, t, d;
        longint unsigned e, f, v;
        rows = clamp_count(m_rows, gerge_pkg::MaxRows);
        cols = clamp_count(m_cols, gerge_pkg::MaxCols);
        r = longint'(signed'(rs));
        t = longint'(signed'(ts));
        d = r - t;
        res = '0;
        sq_sum = add_sat(sq_sum, square_mag(d), Sat61);
        if (row_pos >= 1 && col_pos >= 1) begin
            e = add_sat(square_mag(d - diff_line[col_pos]), square_mag(d - left_diff), Sat63);
            grad_err = add_sat(grad_err, e, Sat63);
            if (m_fld_en) begin
                f = add_sat(square_mag(r - ref_line[col_pos]), square_mag(r - left_ref), Sat63);
                grad_fld = add_sat(grad_fld, f, Sat63);
            end
        end
        diff_line[col_pos] = d;
        ref_line[col_pos] = r;
        left_diff = d;
        left_ref = r;
        if (col_pos + 1 < cols) begin
            col_pos++;
            return 1'b0;
        end
        col_pos = 0;
        if (row_pos + 1 < rows) begin
            row_pos++;
            return 1'b0;
        end
        v = int_sqrt(sq_sum / (longint'(rows) * longint'(cols)));
        res.rmse = v[RmseW-1:0];
        v = scale_energy(grad_err, m_inv);
        res.err_energy = v[EnerW-1:0];
        v = m_fld_en ? scale_energy(grad_fld, m_inv) : 64'd0;
        res.fld_energy = v[EnerW-1:0];
        clear_frame_state();
        return 1'b1;
    endfunction

    task automatic write_reg(logic [IdxW-1:0] idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[DataW-1:0];
        @(posedge i_clk);
        case (idx)
            gerge_pkg::CfgRowCount: m_rows = val & 16'h7FF;
            gerge_pkg::CfgColCount: m_cols = val & 16'h7FF;
            gerge_pkg::CfgInvDhSq:  m_inv = val & 16'hFFFF;
            gerge_pkg::CfgFieldEn:  m_fld_en = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned rows, int unsigned cols, int unsigned inv, bit en);
        write_reg(gerge_pkg::CfgRowCount, rows);
        write_reg(gerge_pkg::CfgColCount, cols);
        write_reg(gerge_pkg::CfgInvDhSq, inv);
        write_reg(gerge_pkg::CfgFieldEn, en);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pause the source until every frame result has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (metrics_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_pair(logic [SB-1:0] rs, logic [SB-1:0] ts,
                             bit typed, t_metrics want);
        int unsigned gap;
        t_metrics res;
        gap = burst_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {rs, ts};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (step_metrics(rs, ts, res)) metrics_q.push_back(typed ? want : res);
    endtask

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SB-1){1'b1}}};
            1: return {1'b1, {(SB-1){1'b0}}};
            2: return SB'($urandom_range(0, 8191)) - SB'(4096);
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic send_frames(int unsigned n);
        int unsigned len;
        logic [SB-1:0] rs, ts;
        len = n * clamp_count(m_rows, gerge_pkg::MaxRows) *
              clamp_count(m_cols, gerge_pkg::MaxCols);
        repeat (len) begin
            if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
            rs = rand_sample();
            // Lossy sample mostly close to the reference, sometimes unrelated
            ts = ($urandom_range(0, 3) == 0) ? rand_sample()
                                              : rs + SB'($urandom_range(0, 63)) - SB'(32);
            send_pair(rs, ts, 1'b0, '0);
        end
    endtask

    // Output side: random stalls, burst stretches, and one long hold-off on request
    initial begin
        int unsigned w;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 9) == 0) rx_burst = ~rx_burst;
                w = rx_burst ? 0 : $urandom_range(0, 19);
                if (w > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_metrics got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = t_metrics'(out_ch.data);
            frames_seen++;
            if (metrics_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result rmse=%0d", got.rmse);
            end else begin
                want = metrics_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame %0d: rmse %0d/%0d err %0d/%0d fld %0d/%0d (exp/act)",
                                 frames_seen, want.rmse, got.rmse, want.err_energy,
                                 got.err_energy, want.fld_energy, got.fld_energy);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    t_stim_row directed [16];

    initial begin
        int unsigned k;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        clear_frame_state();
        foreach (diff_line[j]) begin
            diff_line[j] = 0;
            ref_line[j] = 0;
        end
        // All-zero frame, constant offset frame, extreme frames
        for (k = 0; k < 16; k++) begin
            directed[k].typed = 1'b0;
            directed[k].want = '0;
        end
        for (k = 0; k < 4; k++) begin
            directed[k].ref_s = '0;
            directed[k].test_s = '0;
            directed[4+k].ref_s = 20'd4096;
            directed[4+k].test_s = '0;
            directed[8+k].ref_s = k[0] ? 20'h80000 : 20'h7FFFF;
            directed[8+k].test_s = k[0] ? 20'h7FFFF : 20'h80000;
            directed[12+k].ref_s = (k == 3) ? 20'h80000 : 20'h7FFFF;
            directed[12+k].test_s = 20'hFFFFF;
        end
        directed[3].typed = 1'b1;
        directed[7].typed = 1'b1;
        directed[7].want.rmse = 21'd4096;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        configure(2, 2, 256, 1'b1);
        foreach (directed[j])
            send_pair(directed[j].ref_s, directed[j].test_s, directed[j].typed,
                      directed[j].want);
        drain();

        // Counts below the minimum, full scale factor; then a wide frame, zero scale
        configure(0, 1, 65535, 1'b1);
        send_frames(1);
        drain();
        configure(1, 100, 0, 1'b0);
        send_frames(1);
        drain();

        // Long receiver hold-off while the source keeps offering further frames
        configure(4, 20, 512, 1'b1);
        hold_req = 1'b1;
        burst_mode = 1'b1;
        send_frames(3);
        burst_mode = 1'b0;
        drain();

        while (items_sent < 880) begin
            configure($urandom_range(0, 6), $urandom_range(0, 8),
                      ($urandom_range(0, 4) == 0) ? 65535 * $urandom_range(0, 1)
                                                  : $urandom_range(0, 65535),
                      1'($urandom_range(0, 1)));
            send_frames($urandom_range(1, 3));
            drain();
        end

        repeat (150) @(posedge i_clk);
        $display("Sent %0d sample pairs, checked %0d frame results over varied grid sizes,",
                 items_sent, frames_seen);
        $display("spacing factors and field energy settings; %0d mismatches.", mismatches);
        if (mismatches == 0 && metrics_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
